>>> rtl/core/gtp_pkg.sv
// Shared constants for the go-to-pose velocity controller.
// No dependencies; imported by the controller top level.
package gtp_pkg;

   // Register indexes of the configuration port
   localparam logic [2:0] REG_GOAL_X       = 3'd0;
   localparam logic [2:0] REG_GOAL_Y       = 3'd1;
   localparam logic [2:0] REG_GOAL_HEADING = 3'd2;
   localparam logic [2:0] REG_GAIN_LINEAR  = 3'd3;
   localparam logic [2:0] REG_GAIN_ANGULAR = 3'd4;
   localparam logic [2:0] REG_POS_TOL      = 3'd5;
   localparam logic [2:0] REG_MAX_LINEAR   = 3'd6;
   localparam logic [2:0] REG_MAX_ANGULAR  = 3'd7;

   // Angles are signed Q6.30 radians, held in 36 bits
   localparam logic signed [35:0] PI_Q30     = 36'sd3373259426;
   localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
   localparam logic [29:0]        INV_GAIN_Q30 = 30'd652032874;

   typedef logic signed [35:0] angle_type;

   // Truncated atan(2^-i) table, Q30
   function automatic logic [29:0] atan_lut(input logic [4:0] idx);
      logic [29:0] r;
      begin
         case (idx)
            5'd0:  r = 30'h3243F6A8;
            5'd1:  r = 30'h1DAC6705;
            5'd2:  r = 30'h0FADBAFC;
            5'd3:  r = 30'h07F56EA6;
            5'd4:  r = 30'h03FEAB76;
            5'd5:  r = 30'h01FFD55B;
            5'd6:  r = 30'h00FFFAAA;
            5'd7:  r = 30'h007FFF55;
            5'd8:  r = 30'h003FFFEA;
            5'd9:  r = 30'h001FFFFD;
            5'd10: r = 30'h000FFFFF;
            5'd11: r = 30'h0007FFFF;
            5'd12: r = 30'h0003FFFF;
            5'd13: r = 30'h0001FFFF;
            5'd14: r = 30'h0000FFFF;
            5'd15: r = 30'h00007FFF;
            5'd16: r = 30'h00003FFF;
            5'd17: r = 30'h00001FFF;
            5'd18: r = 30'h00000FFF;
            5'd19: r = 30'h000007FF;
            5'd20: r = 30'h000003FF;
            5'd21: r = 30'h000001FF;
            5'd22: r = 30'h000000FF;
            5'd23: r = 30'h0000007F;
            5'd24: r = 30'h0000003F;
            5'd25: r = 30'h0000001F;
            5'd26: r = 30'h0000000F;
            5'd27: r = 30'h00000007;
            5'd28: r = 30'h00000003;
            5'd29: r = 30'h00000001;
            default: r = 30'h0;
         endcase
         return r;
      end
   endfunction

endpackage

>>> rtl/core/go_to_pose_velocity_controller.sv
// Per pose word: CORDIC vectoring steps, magnitude scale, bearing, wrap and test states,
// then away from the goal the linear product and heading blend before the angular product,
// when turning in place the angular product alone, and when the goal is reached the output
// state directly; a latched goal skips the math. One word at a time: the next pose word is
// taken only once rsp_valid has dropped and the sequencer is idle (shared CORDIC/multiplier).
// Synchronous active-high reset restores the configuration defaults and clears the latch.
// Top level; depends on gtp_pkg.
module go_to_pose_velocity_controller #(
   parameter int HEADING_TOLERANCE = 410,
   parameter int CORDIC_STEPS      = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pose_x,
   input  logic signed [31:0] req_pose_y,
   input  logic signed [15:0] req_pose_heading,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [24:0] rsp_linear_speed,
   output logic signed [24:0] rsp_angular_speed,
   output logic               rsp_goal_reached,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import gtp_pkg::*;

   localparam int SW = $clog2(CORDIC_STEPS + 1);

   // Sequencer codes
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CORD  = 4'd1;
   localparam logic [3:0] ST_MAG   = 4'd2;
   localparam logic [3:0] ST_BEAR  = 4'd3;
   localparam logic [3:0] ST_WRAP  = 4'd4;
   localparam logic [3:0] ST_TEST  = 4'd5;
   localparam logic [3:0] ST_LIN   = 4'd6;
   localparam logic [3:0] ST_BL1   = 4'd7;
   localparam logic [3:0] ST_BL2   = 4'd8;
   localparam logic [3:0] ST_BL3   = 4'd9;
   localparam logic [3:0] ST_ANG   = 4'd10;
   localparam logic [3:0] ST_OUT   = 4'd11;

   localparam angle_type HTOL_Q30 = angle_type'(HEADING_TOLERANCE) <<< 17;

   // Configuration registers
   logic signed [31:0] goal_x_ff, goal_y_ff;
   logic signed [15:0] goal_heading_ff;
   logic [15:0]        gain_lin_ff, gain_ang_ff;
   logic [23:0]        pos_tol_ff, max_lin_ff, max_ang_ff;

   logic               done_ff;
   logic [3:0]         state_ff, state_in;
   logic [SW-1:0]      step_ff;
   logic [1:0]         wcnt_ff;

   // Datapath registers
   logic signed [35:0] x_ff, y_ff;
   angle_type          z_ff, head_ff, ae_ff, fe_ff;
   logic               dxneg_ff, dyneg_ff;
   logic [33:0]        dist_ff;
   logic signed [59:0] acc_ff;
   logic signed [24:0] lin_ff, ang_ff;
   logic               out_valid_ff, out_reached_ff;

   assign csr_ready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign req_stall = (state_ff != ST_IDLE) || out_valid_ff;

   logic req_take;
   assign req_take = req_valid && !req_stall;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff       <= 32'sd131072;
         goal_y_ff       <= 32'sd65536;
         goal_heading_ff <= 16'sd12868;
         gain_lin_ff     <= 16'd128;
         gain_ang_ff     <= 16'd256;
         pos_tol_ff      <= 24'd6554;
         max_lin_ff      <= 24'd32768;
         max_ang_ff      <= 24'd65536;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_GOAL_X:       goal_x_ff       <= csr_data;
            REG_GOAL_Y:       goal_y_ff       <= csr_data;
            REG_GOAL_HEADING: goal_heading_ff <= csr_data[15:0];
            REG_GAIN_LINEAR:  gain_lin_ff     <= csr_data[15:0];
            REG_GAIN_ANGULAR: gain_ang_ff     <= csr_data[15:0];
            REG_POS_TOL:      pos_tol_ff      <= csr_data[23:0];
            REG_MAX_LINEAR:   max_lin_ff      <= csr_data[23:0];
            REG_MAX_ANGULAR:  max_ang_ff      <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // Shared CORDIC step
   logic signed [35:0] x_sh, y_sh;
   angle_type          atan_v;
   assign x_sh   = x_ff >>> step_ff;
   assign y_sh   = y_ff >>> step_ff;
   assign atan_v = angle_type'({1'b0, atan_lut(5'(step_ff))});

   // Differences and their magnitudes
   logic signed [32:0] dx_w, dy_w;
   assign dx_w = 33'(goal_x_ff) - 33'(req_pose_x);
   assign dy_w = 33'(goal_y_ff) - 33'(req_pose_y);

   // Wrap unit: one correction per cycle
   logic signed [35:0] ae_wr, fe_wr;
   function automatic angle_type wrap1(input angle_type a);
      if (a > PI_Q30) return a - TWO_PI_Q30;
      else if (a < -PI_Q30) return a + TWO_PI_Q30;
      else return a;
   endfunction
   assign ae_wr = wrap1(ae_ff);
   assign fe_wr = wrap1(fe_ff);

   // Shared multiplier: 36x31 signed; magnitude scale, gain products and blend weights
   logic signed [35:0] mul_a;
   logic signed [30:0] mul_b;
   logic signed [66:0] prod;
   logic signed [17:0] w_q;
   assign w_q = (dist_ff >= 34'd32768) ? 18'sd65536 : $signed(18'(dist_ff << 1));
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MAG: begin
            mul_a = (x_ff < 0) ? 36'sd0 : x_ff;
            mul_b = $signed({1'b0, INV_GAIN_Q30});
         end
         ST_LIN: begin
            mul_a = $signed({2'b00, dist_ff});
            mul_b = $signed({15'd0, gain_lin_ff});
         end
         ST_BL1: begin
            mul_a = ae_ff;
            mul_b = 31'(w_q);
         end
         ST_BL2: begin
            mul_a = fe_ff;
            mul_b = 31'(18'sd65536 - w_q);
         end
         ST_ANG: begin
            mul_a = 36'(acc_ff);
            mul_b = $signed({15'd0, gain_ang_ff});
         end
         default: ;
      endcase
   end
   assign prod = mul_a * mul_b;

   // Saturation helpers
   logic signed [63:0] lin_rnd, ang_rnd;
   logic signed [24:0] lin_sat, ang_sat;
   assign lin_rnd = 64'((prod + 67'sd128) >>> 8);
   assign ang_rnd = 64'((prod + 67'sd2097152) >>> 22);
   always_comb begin
      lin_sat = (lin_rnd > 64'($signed({1'b0, max_lin_ff})))
              ? 25'($signed({1'b0, max_lin_ff})) : 25'(lin_rnd);
      if (ang_rnd > 64'($signed({1'b0, max_ang_ff})))
         ang_sat = 25'($signed({1'b0, max_ang_ff}));
      else if (ang_rnd < -64'($signed({1'b0, max_ang_ff})))
         ang_sat = -25'($signed({1'b0, max_ang_ff}));
      else
         ang_sat = 25'(ang_rnd);
   end

   logic     far;
   angle_type fe_abs;
   assign far    = dist_ff > 34'(pos_tol_ff);
   assign fe_abs = (fe_ff < 0) ? -fe_ff : fe_ff;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_take) state_in = done_ff ? ST_OUT : ST_CORD;
         ST_CORD: if (step_ff == SW'(CORDIC_STEPS - 1)) state_in = ST_MAG;
         ST_MAG:  state_in = ST_BEAR;
         ST_BEAR: state_in = ST_WRAP;
         ST_WRAP: if (wcnt_ff == 2'd3) state_in = ST_TEST;
         ST_TEST: begin
            if (!far && fe_abs <= HTOL_Q30) state_in = ST_OUT;
            else if (far) state_in = ST_LIN;
            else state_in = ST_ANG;
         end
         ST_LIN:  state_in = ST_BL1;
         ST_BL1:  state_in = ST_BL2;
         ST_BL2:  state_in = ST_BL3;
         ST_BL3:  state_in = ST_ANG;
         ST_ANG:  state_in = ST_OUT;
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
         wcnt_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               step_ff <= '0;
               wcnt_ff <= '0;
               if (req_take) begin
                  lin_ff         <= '0;
                  ang_ff         <= '0;
                  out_reached_ff <= done_ff;
                  dxneg_ff       <= dx_w[32];
                  dyneg_ff       <= dy_w[32];
                  x_ff <= 36'(dx_w[32] ? -dx_w : dx_w);
                  y_ff <= 36'(dy_w[32] ? -dy_w : dy_w);
                  z_ff <= '0;
                  head_ff <= angle_type'(req_pose_heading) <<< 17;
               end
            end
            ST_CORD: begin
               // Advance one vectoring rotation
               if (!y_ff[35]) begin
                  x_ff <= x_ff + y_sh;
                  y_ff <= y_ff - x_sh;
                  z_ff <= z_ff + atan_v;
               end else begin
                  x_ff <= x_ff - y_sh;
                  y_ff <= y_ff + x_sh;
                  z_ff <= z_ff - atan_v;
               end
               step_ff <= step_ff + 1'b1;
            end
            ST_MAG: begin
               dist_ff <= 34'((prod + 67'sd536870912) >>> 30);
               if (dxneg_ff) z_ff <= PI_Q30 - z_ff;
            end
            ST_BEAR: begin
               ae_ff <= (dyneg_ff ? -z_ff : z_ff) - head_ff;
               fe_ff <= (angle_type'(goal_heading_ff) <<< 17) - head_ff;
            end
            ST_WRAP: begin
               ae_ff   <= ae_wr;
               fe_ff   <= fe_wr;
               wcnt_ff <= wcnt_ff + 1'b1;
            end
            ST_TEST: begin
               if (!far && fe_abs <= HTOL_Q30) begin
                  done_ff        <= 1'b1;
                  out_reached_ff <= 1'b1;
               end else if (!far) begin
                  acc_ff <= 60'(fe_ff);
               end
            end
            ST_LIN: lin_ff <= lin_sat;
            ST_BL1: acc_ff <= 60'(prod);
            ST_BL2: acc_ff <= acc_ff + 60'(prod);
            ST_BL3: acc_ff <= acc_ff >>> 16;
            ST_ANG: ang_ff <= ang_sat;
            ST_OUT: out_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_linear_speed  = lin_ff;
   assign rsp_angular_speed = ang_ff;
   assign rsp_goal_reached  = out_reached_ff;

   // A reached result carries zero speeds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_goal_reached |-> rsp_linear_speed == 0 && rsp_angular_speed == 0)
      else $error("reached result with nonzero speed");
   // Done latch never clears outside reset
   assert property (@(posedge clock) disable iff (reset)
      $past(done_ff) && !$past(reset) |-> done_ff)
      else $error("done latch dropped");
   // No new word while busy
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("input taken while busy");
   // Linear speed never negative
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_linear_speed[24])
      else $error("negative linear speed");
endmodule
